>>> design/fsdst_pkg.sv
// Package for the fader sample debounce and speed tracker.
// Holds the sizes, register indexes and the command/status structs that join
// the controller and the datapath. No dependencies.
package fsdst_pkg;

  localparam int CHANNELS        = 8;
  localparam int CH_IDX_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TIME_PER_SAMPLE = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_WEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SPEED  = 2'd2;

  localparam logic [7:0]  DEBOUNCE_LEVEL_RST = 8'd4;
  localparam logic [8:0]  SPEED_WEIGHT_RST   = 9'd26;
  localparam logic [23:0] INITIAL_SPEED_RST  = 24'd2560;

  // The 24-bit quotient is produced two bits per cycle.
  localparam int DIV_W     = 24;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic load_item;
    logic div_init;
    logic div_step;
    logic mul;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } status_t;

endpackage

>>> design/fsdst_ctrl.sv
// Controller state machine for the fader tracker.
// Sequences item capture, the iterative divide, the multiply and the commit.
// Depends on fsdst_pkg.
module fsdst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fsdst_pkg::status_t status_i,
  output fsdst_pkg::cmd_t    cmd_o
);
  import fsdst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_COMMIT
  } state_e;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = status_i.need_div ? ST_DIV : ST_COMMIT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_COMMIT;
      end
      ST_COMMIT: begin
        // Hold here while the previous word still sits in the output register.
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> design/fsdst_dp.sv
// Datapath of the fader tracker: configuration registers, per-channel state,
// radix-4 restoring divider, average multipliers and the output register.
// Depends on fsdst_pkg.
module fsdst_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fsdst_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fsdst_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [fsdst_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic [2:0]                          in_user_i,
  input  fsdst_pkg::cmd_t                     cmd_i,
  output fsdst_pkg::status_t                  status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fsdst_pkg::OUT_DATA_W-1:0]    out_data_o,
  output logic [2:0]                          out_user_o
);
  import fsdst_pkg::*;

  // Configuration registers.
  logic [7:0]  level_q;
  logic [8:0]  weight_q;

  // Per-channel state.
  logic [7:0]  deb_q    [CHANNELS];
  logic [7:0]  last_q   [CHANNELS];
  logic [7:0]  origin_q [CHANNELS];
  logic [7:0]  rep_q    [CHANNELS];
  logic [15:0] rt_q     [CHANNELS];
  logic [23:0] est_q    [CHANNELS];
  logic [7:0]  stall_q  [CHANNELS];

  // Captured item.
  logic [2:0]  ch_q;
  logic [7:0]  smp_q;
  logic        run_q;
  logic        drv_q;

  // Divider and multiplier registers.
  logic [DIV_W-1:0] quo_q;
  logic [7:0]       rem_q;
  logic [7:0]       dvs_q;
  logic [32:0]      prod_a_q;
  logic [32:0]      prod_b_q;

  // Output register.
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [2:0]            out_user_q;

  logic [CH_IDX_W-1:0] idx;
  logic        ch_ok;
  logic [7:0]  prev, deb, rc, org, stall, step;
  logic [15:0] rt, rt_inc;
  logic [23:0] est;
  logic        changed, need_div;
  logic [8:0]  w_eff, inv_w;
  logic [8:0]  r1, r2;
  logic [33:0] mix;

  logic [7:0]  deb_n, rc_n, stall_n, last_n, origin_n;
  logic [15:0] rt_n;
  logic [23:0] est_n;
  logic        stable, ready;

  // One restoring step: returns the quotient bit above the new remainder.
  function automatic logic [8:0] div_bit(input logic [7:0] rem, input logic b,
                                         input logic [7:0] d);
    logic [8:0] part;
    part = {rem, b};
    if (part >= {1'b0, d}) begin
      part = part - {1'b0, d};
      return {1'b1, part[7:0]};
    end
    return {1'b0, part[7:0]};
  endfunction

  assign idx      = CH_IDX_W'(ch_q);
  assign ch_ok    = (int'(ch_q) < CHANNELS);
  assign prev     = last_q[idx];
  assign deb      = deb_q[idx];
  assign rc       = rep_q[idx];
  assign org      = origin_q[idx];
  assign stall    = stall_q[idx];
  assign rt       = rt_q[idx];
  assign est      = est_q[idx];
  assign rt_inc   = run_q ? (rt + 16'(TIME_PER_SAMPLE)) : rt;
  assign step     = (prev >= org) ? (prev - org) : (org - prev);
  assign changed  = (smp_q != prev);
  assign need_div = ch_ok && changed && run_q && (step != 8'd0);

  assign w_eff = weight_q[8] ? 9'd256 : weight_q;
  assign inv_w = 9'd256 - w_eff;

  assign r1 = div_bit(rem_q, quo_q[DIV_W-1], dvs_q);
  assign r2 = div_bit(r1[7:0], quo_q[DIV_W-2], dvs_q);

  assign mix = 34'(prod_a_q) + 34'(prod_b_q);

  always_comb begin
    deb_n    = deb;
    rc_n     = rc;
    stable   = 1'b0;
    ready    = 1'b0;
    rt_n     = rt_inc;
    origin_n = org;
    last_n   = prev;
    stall_n  = stall;
    est_n    = need_div ? mix[31:8] : est;
    if (smp_q != deb) begin
      rc_n = (prev == smp_q) ? (rc + 8'd1) : 8'd0;
      if (rc_n == level_q) begin
        deb_n  = prev;
        rc_n   = 8'd0;
        stable = 1'b1;
        ready  = 1'b1;
      end
    end else begin
      rc_n  = 8'd0;
      ready = (prev == 8'd0);
    end
    if (changed) begin
      if (run_q) begin
        rt_n = 16'd0;
      end
      origin_n = prev;
      stall_n  = 8'd0;
      last_n   = smp_q;
    end else if (drv_q && stall != 8'hFF) begin
      stall_n = stall + 8'd1;
    end
  end

  assign status_o.need_div = need_div;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Configuration and channel state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= DEBOUNCE_LEVEL_RST;
      weight_q <= SPEED_WEIGHT_RST;
      for (int k = 0; k < CHANNELS; k++) begin
        deb_q[k]    <= '0;
        last_q[k]   <= '0;
        origin_q[k] <= '0;
        rep_q[k]    <= '0;
        rt_q[k]     <= '0;
        est_q[k]    <= INITIAL_SPEED_RST;
        stall_q[k]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DEBOUNCE_LEVEL: level_q  <= cfg_data_i[7:0];
          REG_SPEED_WEIGHT:   weight_q <= cfg_data_i[8:0];
          REG_INITIAL_SPEED: begin
            for (int k = 0; k < CHANNELS; k++) begin
              est_q[k] <= cfg_data_i;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.commit && ch_ok) begin
        deb_q[idx]    <= deb_n;
        last_q[idx]   <= last_n;
        origin_q[idx] <= origin_n;
        rep_q[idx]    <= rc_n;
        rt_q[idx]     <= rt_n;
        est_q[idx]    <= est_n;
        stall_q[idx]  <= stall_n;
      end
    end
  end

  // Item capture, divider and multipliers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      ch_q  <= in_user_i;
      smp_q <= in_data_i[7:0];
      run_q <= in_data_i[8];
      drv_q <= in_data_i[9];
    end
    if (cmd_i.div_init) begin
      quo_q <= {rt_inc, 8'd0};
      rem_q <= 8'd0;
      dvs_q <= step;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DIV_W-3:0], r1[8], r2[8]};
      rem_q <= r2[7:0];
    end
    if (cmd_i.mul) begin
      prod_a_q <= 33'(est) * 33'(inv_w);
      prod_b_q <= 33'(w_eff) * 33'(quo_q);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_user_q <= ch_q;
      if (ch_ok) begin
        out_data_q <= {6'd0, est_n, stall_n, ready, stable, deb_n, last_n};
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

>>> design/fader_sample_debounce_speed_tracker_core.sv
// Fader sample debounce and speed tracker, top level.
// Each accepted word is captured, checked and, when the speed is updated, run
// through the 24-bit divider, two quotient bits a cycle, and the multiply before
// its commit; a new word is accepted only after the previous one is committed.
// Reset clears all channel state, loads the default registers and sets every
// speed estimate to 2560; a write of initial_speed reloads all estimates.
module fader_sample_debounce_speed_tracker_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fsdst_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fsdst_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample[7:0], motor_running[8], motor_driven[9], zero fill
  input  logic [fsdst_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // channel[2:0]
  input  logic [2:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // position[7:0], debounced[15:8], new_stable[16], ready_res[17],
  // stall_count[25:18], speed[49:26], zero fill
  output logic [fsdst_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // out_channel[2:0]
  output logic [2:0]                          m_axis_tuser
);
  import fsdst_pkg::*;

  cmd_t    cmd;
  status_t status;

  fsdst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fsdst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

>>> tb/fader_tracker_checker.sv
// Checker for the fader sample debounce and speed tracker: watches the register
// port and both stream channels, keeps its own per-channel tracker state and
// compares every output word with the oldest prediction. Depends on fsdst_pkg.
module fader_tracker_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fsdst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fsdst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  // sample[7:0], motor_running[8], motor_driven[9], zero fill
  input  logic [fsdst_pkg::IN_DATA_W-1:0]  in_data_i,
  // channel[2:0]
  input  logic [2:0]                       in_user_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  // position[7:0], debounced[15:8], new_stable[16], ready_res[17],
  // stall_count[25:18], speed[49:26], zero fill
  input  logic [fsdst_pkg::OUT_DATA_W-1:0] out_data_i,
  // out_channel[2:0]
  input  logic [2:0]                       out_user_i,
  output int                               mismatches_o,
  output int                               pending_o,
  output int                               words_checked_o,
  output int                               acceptances_o,
  output int                               speed_updates_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import fsdst_pkg::*;

  typedef struct packed {
    logic [2:0]  chan;
    logic [7:0]  position;
    logic [7:0]  debounced;
    logic        new_stable;
    logic        ready_res;
    logic [7:0]  stall_count;
    logic [23:0] speed;
  } fader_result_t;

  logic [7:0]  level_reg;
  logic [8:0]  weight_reg;
  logic [23:0] init_speed_reg;

  logic [7:0]  deb_val     [CHANNELS];
  logic [7:0]  last_smp    [CHANNELS];
  logic [7:0]  step_origin [CHANNELS];
  logic [7:0]  repeats     [CHANNELS];
  logic [15:0] run_time    [CHANNELS];
  logic [23:0] speed_est   [CHANNELS];
  logic [7:0]  stalls      [CHANNELS];

  fader_result_t expected_q[$];
  int mismatches;
  int outstanding;
  int words_checked;
  int acceptances;
  int speed_updates;

  assign mismatches_o    = mismatches;
  assign pending_o       = outstanding;
  assign words_checked_o = words_checked;
  assign acceptances_o   = acceptances;
  assign speed_updates_o = speed_updates;

  function automatic fader_result_t track_sample(input logic [2:0] ch,
                                                 input logic [7:0] smp,
                                                 input logic running,
                                                 input logic driven);
    logic [7:0]    prev;
    logic [7:0]    d;
    logic [8:0]    w;
    logic [63:0]   meas;
    logic [63:0]   mix;
    fader_result_t res;
    prev = last_smp[ch];
    res = '0;
    res.chan = ch;

    if (smp != deb_val[ch]) begin
      repeats[ch] = (prev == smp) ? repeats[ch] + 8'd1 : 8'd0;
      if (repeats[ch] == level_reg) begin
        deb_val[ch] = prev;
        repeats[ch] = 8'd0;
        res.new_stable = 1'b1;
        res.ready_res = 1'b1;
        acceptances++;
      end
    end else begin
      repeats[ch] = 8'd0;
      res.ready_res = (prev == 8'd0);
    end

    if (running) run_time[ch] = run_time[ch] + 16'(TIME_PER_SAMPLE);

    if (smp != prev) begin
      if (running) begin
        d = (prev >= step_origin[ch]) ? prev - step_origin[ch] : step_origin[ch] - prev;
        // A step of zero gives no measurement; only the timer restarts.
        if (d != 8'd0) begin
          w = (weight_reg > 9'd256) ? 9'd256 : weight_reg;
          meas = (64'(run_time[ch]) << 8) / 64'(d);
          mix = 64'(speed_est[ch]) * (64'd256 - 64'(w)) + 64'(w) * meas;
          speed_est[ch] = mix[31:8];
          speed_updates++;
        end
        run_time[ch] = 16'd0;
      end
      step_origin[ch] = prev;
      stalls[ch] = 8'd0;
      last_smp[ch] = smp;
    end else if (driven && stalls[ch] != 8'hFF) begin
      stalls[ch] = stalls[ch] + 8'd1;
    end

    res.position = last_smp[ch];
    res.debounced = deb_val[ch];
    res.stall_count = stalls[ch];
    res.speed = speed_est[ch];
    return res;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fader_result_t want;
    if (!rst_ni) begin
      level_reg = DEBOUNCE_LEVEL_RST;
      weight_reg = SPEED_WEIGHT_RST;
      init_speed_reg = INITIAL_SPEED_RST;
      for (int k = 0; k < CHANNELS; k++) begin
        deb_val[k] = 8'd0;
        last_smp[k] = 8'd0;
        step_origin[k] = 8'd0;
        repeats[k] = 8'd0;
        run_time[k] = 16'd0;
        speed_est[k] = INITIAL_SPEED_RST;
        stalls[k] = 8'd0;
      end
      expected_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE_LEVEL: level_reg = cfg_data_i[7:0];
          REG_SPEED_WEIGHT:   weight_reg = cfg_data_i[8:0];
          REG_INITIAL_SPEED: begin
            init_speed_reg = cfg_data_i;
            for (int k = 0; k < CHANNELS; k++) speed_est[k] = cfg_data_i;
          end
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(track_sample(in_user_i, in_data_i[7:0], in_data_i[8],
                                          in_data_i[9]));
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("output word on channel %0d with no sample waiting", out_user_i);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          words_checked++;
          compare_field("out_channel", want.chan, out_user_i);
          compare_field("position", want.position, out_data_i[7:0]);
          compare_field("debounced", want.debounced, out_data_i[15:8]);
          compare_field("new_stable", want.new_stable, out_data_i[16]);
          compare_field("ready_res", want.ready_res, out_data_i[17]);
          compare_field("stall_count", want.stall_count, out_data_i[25:18]);
          compare_field("speed", want.speed, out_data_i[49:26]);
        end
      end

      outstanding <= expected_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the fader tracker testbench: clock, reset, register writes and sample
// stimulus with random idling on both stream sides. Depends on fsdst_pkg, the
// tracker core and fader_tracker_checker, which does all predicting and checking.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fsdst_pkg::*;

  // The register port decodes two bits; this index selects nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [2:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0]            m_axis_tuser;

  logic steady = 1'b0;     // no random idling on either side while set
  logic hold_req = 1'b0;   // asks the sink for one long hold-off
  logic hold_done = 1'b0;

  int mismatches;
  int pending;
  int words_checked;
  int acceptances;
  int speed_updates;
  int items_sent = 0;
  logic [7:0] level_now = DEBOUNCE_LEVEL_RST;
  logic [7:0] pos_hint [CHANNELS];

  always #5 clk_i = ~clk_i;

  fader_sample_debounce_speed_tracker_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  fader_tracker_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_i      (s_axis_tready),
    .in_data_i       (s_axis_tdata),
    .in_user_i       (s_axis_tuser),
    .out_valid_i     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_i      (m_axis_tdata),
    .out_user_i      (m_axis_tuser),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .words_checked_o (words_checked),
    .acceptances_o   (acceptances),
    .speed_updates_o (speed_updates)
  );

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_done <= 1'b1;
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 14);
    end
  end

  initial begin
    #(5_000_000);
    $display("testbench failed");
    $finish;
  end

  task automatic send_sample(input logic [2:0] ch, input logic [7:0] smp,
                             input logic running, input logic driven);
    while (!steady && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_DATA_W'({driven, running, smp});
    s_axis_tuser <= ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Stops offering words and waits until every predicted word has come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One fader movement: a channel settles on a new position for a few samples,
  // sometimes with a noisy reading in between.
  task automatic random_run();
    logic [2:0] ch;
    logic [7:0] target;
    logic [7:0] smp;
    logic       running;
    int         reps;
    ch = 3'($urandom_range(CHANNELS - 1));
    case ($urandom_range(3))
      0: target = 8'($urandom);
      1: target = pos_hint[ch] - 8'($urandom_range(1, 6));
      default: target = pos_hint[ch] + 8'($urandom_range(1, 6));
    endcase
    reps = $urandom_range(1, (level_now > 8'd10) ? 12 : level_now + 2);
    running = ($urandom_range(99) < 80);
    for (int k = 0; k < reps; k++) begin
      smp = ($urandom_range(99) < 8) ? 8'($urandom) : target;
      send_sample(ch, smp, ($urandom_range(99) < 90) ? running : !running,
                  1'($urandom_range(1)));
    end
    pos_hint[ch] = target;
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_run();
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] data;
    for (int k = 0; k < CHANNELS; k++) pos_hint[k] = 8'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset settings.
    send_sample(3'd0, 8'd0, 1'b0, 1'b1);     // at rest on zero
    send_sample(3'd1, 8'd255, 1'b1, 1'b1);   // step from origin zero: no update
    repeat (4) send_sample(3'd1, 8'd255, 1'b1, 1'b1);  // accepted on the last
    send_sample(3'd2, 8'd10, 1'b1, 1'b0);
    send_sample(3'd2, 8'd20, 1'b1, 1'b0);
    send_sample(3'd2, 8'd5, 1'b1, 1'b1);
    send_sample(3'd2, 8'd5, 1'b0, 1'b1);
    send_sample(3'd7, 8'd128, 1'b1, 1'b1);
    send_sample(3'd7, 8'd127, 1'b1, 1'b0);
    send_sample(3'd7, 8'd128, 1'b1, 1'b1);
    send_sample(3'd7, 8'd255, 1'b0, 1'b0);
    send_sample(3'd7, 8'd0, 1'b1, 1'b1);
    send_sample(3'd4, 8'd0, 1'b1, 1'b0);

    // Random with the reset settings, including a long sink hold-off while the
    // source keeps offering words, and one full drain in the middle.
    random_phase(60);
    steady <= 1'b1;
    hold_req <= 1'b1;
    random_phase(40);
    steady <= 1'b0;
    random_phase(40);
    settle();
    random_phase(40);
    settle();

    // Debounce level one, new measurements ignored, largest start speed.
    write_reg(REG_DEBOUNCE_LEVEL, 24'd1);
    level_now = 8'd1;
    write_reg(REG_SPEED_WEIGHT, 24'd0);
    write_reg(REG_INITIAL_SPEED, 24'hFFFFFF);
    random_phase(120);
    settle();

    // Longest debounce, full weight, zero start speed. One channel then holds
    // still long enough to reach the debounce level and saturate its stall
    // count before it moves again.
    write_reg(REG_DEBOUNCE_LEVEL, 24'd255);
    level_now = 8'd255;
    write_reg(REG_SPEED_WEIGHT, 24'd256);
    write_reg(REG_INITIAL_SPEED, 24'd0);
    steady <= 1'b1;
    send_sample(3'd3, 8'd20, 1'b1, 1'b0);
    send_sample(3'd3, 8'd40, 1'b1, 1'b1);
    repeat (260) send_sample(3'd3, 8'd40, 1'b1, 1'b1);
    send_sample(3'd3, 8'd41, 1'b1, 1'b1);
    steady <= 1'b0;
    random_phase(70);
    settle();

    // Debounce level zero, an oversized weight, and a write to an unused index.
    write_reg(REG_DEBOUNCE_LEVEL, 24'd0);
    level_now = 8'd0;
    write_reg(REG_SPEED_WEIGHT, 24'd511);
    data = 24'($urandom);
    write_reg(REG_INITIAL_SPEED, data);
    write_reg(REG_UNUSED, 24'($urandom));
    random_phase(75);
    settle();

    // Random settings, with junk in the unused upper data bits.
    data = 24'($urandom);
    data[7:0] = 8'($urandom_range(1, 12));
    write_reg(REG_DEBOUNCE_LEVEL, data);
    level_now = data[7:0];
    data = 24'($urandom);
    data[8:0] = 9'($urandom_range(1, 300));
    write_reg(REG_SPEED_WEIGHT, data);
    write_reg(REG_INITIAL_SPEED, 24'($urandom));
    random_phase(75);
    settle();

    $display("Sent %0d samples over five register settings; checked %0d output words.",
             items_sent, words_checked);
    $display("Saw %0d debounce acceptances and %0d speed updates.",
             acceptances, speed_updates);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
